// File: src/dsm2_pkg.sv
package dsm2_pkg;

    localparam int NUM_CHANNELS = 8;

    localparam int GAP_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int RSLOT_W = 3;
    localparam int SLOT_W  = 4;
    localparam int VALUE_W = 11;
    localparam int MAP_W   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // index width into the channel table, never below one bit
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [GAP_W-1:0] GAP_THRESHOLD_RESET = 16'd5000;
    localparam logic [MAP_W-1:0] CHANNEL_MAP_RESET   = 48'hBA98_7654_3210;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_BYTE = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic {
        KIND_PAIR = 1'b0,
        KIND_READ = 1'b1
    } kind_t;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MAP   = 2'd2;

    // one decoded channel pair, handed from the frame tracker to the top level
    typedef struct packed {
        logic               valid;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
        logic               stored;
    } pair_t;

endpackage

// File: src/dsm2_item_if.sv
interface dsm2_item_if;
    import dsm2_pkg::*;

    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [BYTE_W-1:0]  data_byte;
    logic [RSLOT_W-1:0] read_slot;

    modport source (output valid, output op, output data_byte, output read_slot, input ready);
    modport sink   (input valid, input op, input data_byte, input read_slot, output ready);
endinterface

// File: src/dsm2_result_if.sv
interface dsm2_result_if;
    import dsm2_pkg::*;

    logic               valid;
    logic               ready;
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               stored;

    modport source (output valid, output kind, output slot, output value, output stored,
                    input ready);
    modport sink   (input valid, input kind, input slot, input value, input stored,
                    output ready);
endinterface

// File: src/dsm2_frame_tracker.sv
module dsm2_frame_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           fire,
    input  logic [1:0]                     op,
    input  logic [dsm2_pkg::BYTE_W-1:0]    data_byte,
    input  logic [dsm2_pkg::GAP_W-1:0]     gap_threshold,
    input  logic                           wide_mode,
    input  logic [dsm2_pkg::MAP_W-1:0]     channel_map,
    output dsm2_pkg::pair_t                pair
);
    import dsm2_pkg::*;

    typedef enum logic [1:0] {
        PH_NEW_FRAME   = 2'd0,
        PH_WAIT_FIRST  = 2'd1,
        PH_WAIT_SECOND = 2'd2
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [GAP_W-1:0]   gap_reg, gap_next;
    logic [BYTE_W-1:0]  first_reg, first_next;

    logic               long_gap;
    logic [SLOT_W-1:0]  chan;
    logic [SLOT_W-1:0]  mapped;
    logic [VALUE_W-1:0] value;

    assign long_gap = gap_reg > gap_threshold;

    // channel number and high value bits sit at different places per mode
    always_comb
    begin
        if (wide_mode)
        begin
            chan  = first_reg[6:3];
            value = {first_reg[2:0], data_byte};
        end
        else
        begin
            chan  = first_reg[5:2];
            value = {1'b0, first_reg[1:0], data_byte};
        end
    end

    assign mapped = channel_map[SLOT_W*chan +: SLOT_W];

    always_comb
    begin
        phase_next = phase_reg;
        gap_next   = gap_reg;
        first_next = first_reg;
        pair       = '0;
        if (fire && (op == OP_TICK))
        begin
            if (gap_reg != '1)
                gap_next = gap_reg + 1'b1;
        end
        else if (fire && (op == OP_BYTE))
        begin
            gap_next = '0;
            if (long_gap)
                phase_next = PH_NEW_FRAME;
            else
            begin
                unique case (phase_reg)
                    PH_NEW_FRAME:
                    begin
                        phase_next = PH_WAIT_FIRST;
                    end
                    PH_WAIT_FIRST:
                    begin
                        first_next = data_byte;
                        phase_next = PH_WAIT_SECOND;
                    end
                    default:
                    begin
                        phase_next  = PH_WAIT_FIRST;
                        pair.valid  = 1'b1;
                        pair.value  = value;
                        pair.slot   = chan;
                        if (chan < SLOT_W'(NUM_CHANNELS))
                        begin
                            pair.slot = mapped;
                            if (mapped < SLOT_W'(NUM_CHANNELS))
                                pair.stored = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_NEW_FRAME;
            gap_reg   <= '0;
            first_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            gap_reg   <= gap_next;
            first_reg <= first_next;
        end
    end

endmodule

// File: src/dsm2_value_store.sv
module dsm2_value_store (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [dsm2_pkg::SLOT_W-1:0]   wr_slot,
    input  logic [dsm2_pkg::VALUE_W-1:0]  wr_value,
    input  logic [dsm2_pkg::SLOT_W-1:0]   rd_slot,
    output logic [dsm2_pkg::VALUE_W-1:0]  rd_value
);
    import dsm2_pkg::*;

    logic [VALUE_W-1:0] values_reg [NUM_CHANNELS];

    // slots beyond the table read as zero
    always_comb
    begin
        if (rd_slot < SLOT_W'(NUM_CHANNELS))
            rd_value = values_reg[rd_slot[IDX_W-1:0]];
        else
            rd_value = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                values_reg[i] <= '0;
        end
        else if (wr_en)
        begin
            values_reg[wr_slot[IDX_W-1:0]] <= wr_value;
        end
    end

endmodule

// File: src/dsm2_serial_channel_decoder.sv
// path: a beat accepted into the input register is decoded from it; its result beat is
//   offered from the result register. Throughput, while the result side does not stall:
//   one beat per cycle, set by the single decode pass between the two registers
// reset: asynchronous active low; clears gap counter, frame phase, first byte, the
//   channel table and restores the configuration registers to their defaults
module dsm2_serial_channel_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    dsm2_item_if.sink                         item,
    dsm2_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [dsm2_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dsm2_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import dsm2_pkg::*;

    // configuration registers
    logic [GAP_W-1:0] gap_threshold_reg;
    logic             wide_mode_reg;
    logic [MAP_W-1:0] channel_map_reg;

    // input register
    logic               stg_valid_reg;
    logic [1:0]         stg_op_reg;
    logic [BYTE_W-1:0]  stg_byte_reg;
    logic [RSLOT_W-1:0] stg_rslot_reg;

    // result register
    logic               res_valid_reg, res_valid_next;
    logic               res_kind_reg, res_kind_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [VALUE_W-1:0] res_value_reg, res_value_next;
    logic               res_stored_reg, res_stored_next;

    logic               advance;
    logic               take_item;
    pair_t              pair;
    logic [SLOT_W-1:0]  rd_slot;
    logic [VALUE_W-1:0] rd_value;

    // the staged beat moves on whenever the result register is free or being emptied
    assign advance   = stg_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !stg_valid_reg || advance;
    assign take_item  = item.valid && item.ready;

    // configuration writes, indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_threshold_reg <= GAP_THRESHOLD_RESET;
            wide_mode_reg     <= 1'b0;
            channel_map_reg   <= CHANNEL_MAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAP_THRESHOLD: gap_threshold_reg <= cfg_wdata[GAP_W-1:0];
                CFG_WIDE_MODE:     wide_mode_reg     <= cfg_wdata[0];
                CFG_CHANNEL_MAP:   channel_map_reg   <= cfg_wdata[MAP_W-1:0];
                default:           ;
            endcase
        end
    end

    // input register, payload held while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (item.ready)
            stg_valid_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            stg_op_reg    <= item.op;
            stg_byte_reg  <= item.data_byte;
            stg_rslot_reg <= item.read_slot;
        end
    end

    // gap timing, frame phase and pair decode
    dsm2_frame_tracker u_tracker (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .op            (stg_op_reg),
        .data_byte     (stg_byte_reg),
        .gap_threshold (gap_threshold_reg),
        .wide_mode     (wide_mode_reg),
        .channel_map   (channel_map_reg),
        .pair          (pair)
    );

    assign rd_slot = {1'b0, stg_rslot_reg};

    // stored channel values, written by decoded pairs and read by read beats
    dsm2_value_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (pair.valid && pair.stored),
        .wr_slot  (pair.slot),
        .wr_value (pair.value),
        .rd_slot  (rd_slot),
        .rd_value (rd_value)
    );

    // result register: a read beat or a decoded pair fills it, ticks and skipped
    // bytes leave it empty
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_kind_next   = res_kind_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        res_stored_next = res_stored_reg;
        if (result.ready)
            res_valid_next = 1'b0;
        if (advance)
        begin
            if (stg_op_reg == OP_READ)
            begin
                res_valid_next  = 1'b1;
                res_kind_next   = KIND_READ;
                res_slot_next   = rd_slot;
                res_value_next  = rd_value;
                res_stored_next = 1'b0;
            end
            else if (pair.valid)
            begin
                res_valid_next  = 1'b1;
                res_kind_next   = KIND_PAIR;
                res_slot_next   = pair.slot;
                res_value_next  = pair.value;
                res_stored_next = pair.stored;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_kind_reg   <= res_kind_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        res_stored_reg <= res_stored_next;
    end

    assign result.valid  = res_valid_reg;
    assign result.kind   = res_kind_reg;
    assign result.slot   = res_slot_reg;
    assign result.value  = res_value_reg;
    assign result.stored = res_stored_reg;

endmodule
